// ----- src/bbht_pkg.sv -----
// Shared types and constants for the bounded bucket hash table.
// Field widths, status and request codes, stored entry layout.
// No dependencies.
package bbht_pkg;

	localparam int KEY_W      = 31;
	localparam int VAL_W      = 64;
	localparam int CFG_W      = 9;
	localparam int STATUS_W   = 3;
	localparam int IN_TDATA_W = ((KEY_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((VAL_W + 7) / 8) * 8;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_DUPLICATE = 3'd4
	} status_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

endpackage

// ----- src/bbht_mod_unit.sv -----
// Iterative restoring remainder unit: key modulo bucket count, one bit a cycle.
// Depends on bbht_pkg for the key width.
module bbht_mod_unit #(
	parameter int DVW = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bbht_pkg::KEY_W-1:0] dividend,
	input  logic [DVW-1:0]            divisor,
	output logic                      done,
	output logic [DVW-1:0]            remainder
);

	localparam int CNT_W = $clog2(bbht_pkg::KEY_W + 1);

	logic [bbht_pkg::KEY_W-1:0] quo_q;
	logic [DVW-1:0]             rem_q;
	logic [DVW-1:0]             dvs_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [DVW:0]               partial;
	logic [DVW:0]               trial;

	assign partial = {rem_q, quo_q[bbht_pkg::KEY_W-1]};
	assign trial   = partial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(bbht_pkg::KEY_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: shift the dividend in, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[bbht_pkg::KEY_W-2:0], 1'b0};
			rem_q <= trial[DVW] ? partial[DVW-1:0] : trial[DVW-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- src/bounded_bucket_hash_table_core.sv -----
// Top level of the bounded bucket hash table: stream ports, sequencer,
// fill-count and entry memories. Depends on bbht_pkg and bbht_mod_unit.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tuser: req_type; s_tdata: key, value_in
//  m_*       out        m_tvalid/m_tready  m_tuser: status; m_tdata: value_out
//  config    in         bucket_count_we    bucket_count_wdata: bucket_count
//
// One item at a time: after an accepted transfer the block runs 31 remainder
// steps, takes the bucket index, reads the memories, evaluates and returns to
// idle before it accepts the next one. After reset a clearing pass zeroes the
// fill counts of all NUM_BUCKETS buckets while s_tready stays low. A result
// waiting on m_* does not block the next input transfer; only the evaluate
// step holds until the output register frees.
module bounded_bucket_hash_table_core #(
	parameter int NUM_BUCKETS = 256,
	parameter int WAYS        = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 bucket_count_we,
	input  logic [bbht_pkg::CFG_W-1:0]           bucket_count_wdata,
	// requests
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [bbht_pkg::IN_TDATA_W-1:0]      s_tdata,  // [30:0] key, [94:31] value_in, [95] unused
	input  logic                                 s_tuser,  // [0] req_type
	// results
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bbht_pkg::OUT_TDATA_W-1:0]     m_tdata,  // [63:0] value_out
	output logic [bbht_pkg::STATUS_W-1:0]        m_tuser   // [2:0] status
);

	localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CW  = $clog2(WAYS + 1);
	localparam int NBW = $clog2(NUM_BUCKETS + 1);
	// bucket count register is wide enough for its reset value
	localparam int BCW = (NBW > bbht_pkg::CFG_W) ? NBW : bbht_pkg::CFG_W;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_DIV   = 5'b00100,
		S_READ  = 5'b01000,
		S_EVAL  = 5'b10000
	} state_t;

	state_t state_q;

	// ---------------------------------------------------------------- config
	logic [BCW-1:0] bucket_count_q;
	logic [BCW-1:0] eff_buckets;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BCW'(NUM_BUCKETS);
		end else if (bucket_count_we) begin
			bucket_count_q <= BCW'(bucket_count_wdata);
		end
	end

	// zero means one bucket, above the table size saturates
	always_comb begin
		priority if (bucket_count_q == '0) begin
			eff_buckets = BCW'(1);
		end else if (bucket_count_q > BCW'(NUM_BUCKETS)) begin
			eff_buckets = BCW'(NUM_BUCKETS);
		end else begin
			eff_buckets = bucket_count_q;
		end
	end

	// --------------------------------------------------------- request hold
	logic                          in_xfer;
	bbht_pkg::req_t                req_q;
	logic [bbht_pkg::KEY_W-1:0]    key_q;
	logic [bbht_pkg::VAL_W-1:0]    value_q;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q   <= bbht_pkg::req_t'(s_tuser);
			key_q   <= s_tdata[bbht_pkg::KEY_W-1:0];
			value_q <= s_tdata[bbht_pkg::KEY_W +: bbht_pkg::VAL_W];
		end
	end

	// -------------------------------------------------------- bucket index
	logic                 mod_done;
	logic [BCW-1:0]       mod_rem;
	logic [BW+BCW-1:0]    rem_wide;
	logic [BW-1:0]        bucket_q;

	bbht_mod_unit #(
		.DVW(BCW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_xfer),
		.dividend (s_tdata[bbht_pkg::KEY_W-1:0]),
		.divisor  (eff_buckets),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	// remainder stays below the effective count, so it fits the index
	assign rem_wide = {{BW{1'b0}}, mod_rem};

	always_ff @(posedge clk) begin
		if (state_q == S_DIV && mod_done) begin
			bucket_q <= rem_wide[BW-1:0];
		end
	end

	// ------------------------------------------------------------ memories
	logic [CW-1:0]                  fill_mem [NUM_BUCKETS];
	bbht_pkg::entry_t [WAYS-1:0]    tbl_mem  [NUM_BUCKETS];
	logic [CW-1:0]                  fill_rd_q;
	bbht_pkg::entry_t [WAYS-1:0]    row_rd_q;
	logic [BW-1:0]                  clr_q;
	logic                           fill_we;
	logic [BW-1:0]                  fill_wa;
	logic [CW-1:0]                  fill_wd;
	logic                           tbl_we;
	logic                           eval_go;

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			fill_rd_q <= fill_mem[bucket_q];
			row_rd_q  <= tbl_mem[bucket_q];
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_wa] <= fill_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[bucket_q][fill_rd_q[WW-1:0]] <= '{key: key_q, value: value_q};
		end
	end

	// ---------------------------------------------------------- evaluate
	logic [WAYS-1:0]          hits;
	logic                     hit_any;
	logic [WW-1:0]            hit_idx;
	logic                     full;
	bbht_pkg::status_t        status_nx;
	logic [bbht_pkg::VAL_W-1:0] value_nx;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hits[w] = (fill_rd_q > CW'(w)) && (row_rd_q[w].key == key_q);
		end
	end

	// first match in fill order wins
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hits[w]) begin
				hit_any = 1'b1;
				hit_idx = WW'(w);
			end
		end
	end

	assign full = (fill_rd_q >= CW'(WAYS));

	always_comb begin
		value_nx = '0;
		unique case (req_q)
			bbht_pkg::REQ_INSERT: begin
				priority if (hit_any) begin
					status_nx = bbht_pkg::ST_DUPLICATE;
				end else if (full) begin
					status_nx = bbht_pkg::ST_FULL;
				end else begin
					status_nx = bbht_pkg::ST_INSERTED;
				end
			end
			bbht_pkg::REQ_LOOKUP: begin
				if (hit_any) begin
					status_nx = bbht_pkg::ST_FOUND;
					value_nx  = row_rd_q[hit_idx].value;
				end else begin
					status_nx = bbht_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				status_nx = bbht_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	// hold the evaluate step until the output register is free
	assign eval_go = (state_q == S_EVAL) && (!m_tvalid || m_tready);
	assign tbl_we  = eval_go && (status_nx == bbht_pkg::ST_INSERTED);

	always_comb begin
		if (state_q == S_CLEAR) begin
			fill_we = 1'b1;
			fill_wa = clr_q;
			fill_wd = '0;
		end else begin
			fill_we = tbl_we;
			fill_wa = bucket_q;
			fill_wd = fill_rd_q + 1'b1;
		end
	end

	// ---------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(NUM_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (mod_done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (eval_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ----------------------------------------------------- output register
	logic                         out_valid_q;
	bbht_pkg::status_t            out_status_q;
	logic [bbht_pkg::VAL_W-1:0]   out_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eval_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_go) begin
			out_status_q <= status_nx;
			out_value_q  <= value_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = bbht_pkg::OUT_TDATA_W'(out_value_q);

	// ---------------------------------------------------------- assertions
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> fill_rd_q <= CW'(WAYS))
		else $error("fill count read above way count");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != bbht_pkg::ST_FOUND |-> m_tdata == '0)
		else $error("nonzero value on a result other than found");

	a_mod_done_div: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == S_DIV)
		else $error("remainder done outside the divide state");

	a_insert_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> !full && !hit_any && req_q == bbht_pkg::REQ_INSERT)
		else $error("entry write without room or with a duplicate");

endmodule
